// File: src/assert_macros.svh
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: src/slfp_pkg.sv
// Constants and types for the status line field parser
`default_nettype none
package slfp_pkg;

  localparam logic [3:0] VERSION_CHARS = 4'd8;
  localparam logic [3:0] FIELD_COUNT   = 4'd9;
  localparam logic [3:0] FIELD_KEEP    = 4'd9;
  localparam logic [3:0] TEXT_FIELD    = 4'd8;
  localparam logic [3:0] POWER_FIELD   = 4'd6;
  localparam logic [3:0] LAST_NUM_FIELD = 4'd7;
  localparam logic [3:0] COUNT_MAX     = 4'd15;

  localparam logic [7:0] SEP_BYTE   = 8'h3a;
  localparam logic [7:0] END_BYTE   = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0b;
  localparam logic [7:0] CH_FFEED   = 8'h0c;
  localparam logic [7:0] CH_CRET    = 8'h0d;

  // Number scan phase within a numeric field
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) ||
           (b == CH_FFEED) || (b == CH_CRET);
  endfunction

endpackage
`default_nettype wire

// File: src/status_line_field_parser.sv
// Status line field parser: top level
//
// Usage: feed the received bytes of one status reply line on the in_
// channel (in_valid/in_ready, payload in_rx_byte). Colon separates fields,
// newline ends the line. Every other byte only updates the parse state and
// gives no result. A newline word yields one status record on the out_
// channel (out_valid/out_ready), registered at the edge that accepts it.
// Throughput: one byte per cycle while in_ready is high; each byte passes
// through one level of parse logic into the state and record registers, and
// the record is loaded into a single output register.
// Stall: while a record waits in the output register and out_ready is low,
// in_ready is low; the next byte is taken in the same cycle the record
// is taken. Nothing is dropped.
// Reset: rst_n low at a clock edge clears the parse state, the stored
// fields and the output valid flag; the block is ready right after.
`default_nettype none
`include "assert_macros.svh"

module status_line_field_parser
  import slfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_battery_level,
  output logic [6:0]       out_level_a,
  output logic [6:0]       out_level_b,
  output logic [6:0]       out_duty_value,
  output logic [6:0]       out_feel_value,
  output logic [7:0]       out_mode_number,
  output logic [7:0]       out_power_code,
  output logic [7:0]       out_linked_value,
  output logic [63:0]      out_version_text,
  output logic [3:0]       out_version_length,
  output logic             out_overflow_flag
);

  // parse state
  logic [3:0]  field_index_r, field_index_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_char_r, first_char_nxt;
  logic [63:0] text_r, text_nxt;
  logic [3:0]  text_count_r, text_count_nxt;
  logic        overflow_r, overflow_nxt;
  logic [7:0]  rec_r [8];
  logic [7:0]  rec_nxt [8];
  logic [3:0]  char_count_r, char_count_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_rec_r [8];
  logic [63:0] out_text_r;
  logic [3:0]  out_len_r;
  logic        out_ovf_r;

  logic        in_fire;
  logic        is_sep, is_end, is_delim;
  logic        take_en, is_text, close_en;
  logic        digit;
  logic [7:0]  dval;
  logic [7:0]  acc_mul;
  logic [7:0]  num_val, close_val;
  logic [7:0]  rec_view [8];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_sep   = (in_rx_byte == SEP_BYTE);
  assign is_end   = (in_rx_byte == END_BYTE);
  assign is_delim = is_sep || is_end;
  assign take_en  = (field_index_r < FIELD_COUNT) && (field_index_r <= TEXT_FIELD);
  assign is_text  = (field_index_r == TEXT_FIELD);
  assign close_en = (field_index_r < FIELD_COUNT) && (field_index_r <= LAST_NUM_FIELD);

  assign digit    = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
  assign dval     = in_rx_byte - CH_ZERO;
  // acc * 10 + digit, modulo 256
  assign acc_mul  = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0} + dval;

  // value of the open field when it closes
  always_comb begin
    if (phase_r == PH_SIGN) begin
      num_val = 8'd0;
    end else if (neg_r) begin
      num_val = 8'd0 - acc_r;
    end else begin
      num_val = acc_r;
    end
    if (field_index_r == POWER_FIELD) begin
      close_val = first_char_r;
    end else if ((field_index_r >= 4'd1) && (field_index_r <= 4'd4)) begin
      close_val = {1'b0, num_val[7:1]};
    end else begin
      close_val = num_val;
    end
  end

  // stored fields with the closing field merged in
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (close_en && (field_index_r[2:0] == 3'(k))) begin
        rec_view[k] = close_val;
      end else begin
        rec_view[k] = rec_r[k];
      end
    end
  end

  // next number phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (is_delim) begin
        phase_nxt = PH_LEAD;
      end else if (take_en) begin
        if (is_text) begin
          if ((char_count_r < VERSION_CHARS) && (phase_r != PH_STOP) &&
              (in_rx_byte == 8'd0)) begin
            phase_nxt = PH_STOP;
          end
        end else if ((char_count_r < FIELD_KEEP) && (field_index_r != POWER_FIELD)) begin
          case (phase_r)
            PH_LEAD: begin
              if (is_blank(in_rx_byte)) begin
                phase_nxt = PH_LEAD;
              end else if ((in_rx_byte == CH_PLUS) || (in_rx_byte == CH_MINUS)) begin
                phase_nxt = PH_SIGN;
              end else if (digit) begin
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
            PH_SIGN: begin
              phase_nxt = digit ? PH_DIGITS : PH_STOP;
            end
            PH_DIGITS: begin
              phase_nxt = digit ? PH_DIGITS : PH_STOP;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  // next data state
  always_comb begin
    field_index_nxt = field_index_r;
    acc_nxt         = acc_r;
    neg_nxt         = neg_r;
    first_char_nxt  = first_char_r;
    text_nxt        = text_r;
    text_count_nxt  = text_count_r;
    overflow_nxt    = overflow_r;
    char_count_nxt  = char_count_r;
    for (int k = 0; k < 8; k++) begin
      rec_nxt[k] = rec_r[k];
    end
    if (in_fire) begin
      if (is_delim) begin
        // close the field and advance
        for (int k = 0; k < 8; k++) begin
          rec_nxt[k] = rec_view[k];
        end
        field_index_nxt = (field_index_r < COUNT_MAX) ? field_index_r + 4'd1 : field_index_r;
        acc_nxt         = 8'd0;
        neg_nxt         = 1'b0;
        first_char_nxt  = 8'd0;
        char_count_nxt  = 4'd0;
        if (is_end) begin
          // drop the whole record after it is emitted
          field_index_nxt = 4'd0;
          text_nxt        = 64'd0;
          text_count_nxt  = 4'd0;
          overflow_nxt    = 1'b0;
          for (int k = 0; k < 8; k++) begin
            rec_nxt[k] = 8'd0;
          end
        end
      end else if (take_en) begin
        if (char_count_r < COUNT_MAX) begin
          char_count_nxt = char_count_r + 4'd1;
        end
        if (is_text) begin
          if (char_count_r >= VERSION_CHARS) begin
            overflow_nxt = 1'b1;
          end else if ((phase_r != PH_STOP) && (in_rx_byte != 8'd0)) begin
            text_nxt[{char_count_r[2:0], 3'b000} +: 8] = in_rx_byte;
            text_count_nxt = char_count_r + 4'd1;
          end
        end else if (char_count_r >= FIELD_KEEP) begin
          overflow_nxt = 1'b1;
        end else begin
          if (char_count_r == 4'd0) begin
            first_char_nxt = in_rx_byte;
          end
          if (field_index_r != POWER_FIELD) begin
            case (phase_r)
              PH_LEAD: begin
                if (!is_blank(in_rx_byte) && (in_rx_byte == CH_MINUS)) begin
                  neg_nxt = 1'b1;
                end else if (!is_blank(in_rx_byte) && (in_rx_byte != CH_PLUS) && digit) begin
                  acc_nxt = dval;
                end
              end
              PH_SIGN: begin
                if (digit) begin
                  acc_nxt = dval;
                end
              end
              PH_DIGITS: begin
                if (digit) begin
                  acc_nxt = acc_mul;
                end
              end
              default: begin
                acc_nxt = acc_r;
              end
            endcase
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r <= 4'd0;
      acc_r         <= 8'd0;
      neg_r         <= 1'b0;
      phase_r       <= PH_LEAD;
      first_char_r  <= 8'd0;
      text_r        <= 64'd0;
      text_count_r  <= 4'd0;
      overflow_r    <= 1'b0;
      char_count_r  <= 4'd0;
      for (int k = 0; k < 8; k++) begin
        rec_r[k] <= 8'd0;
      end
    end else begin
      field_index_r <= field_index_nxt;
      acc_r         <= acc_nxt;
      neg_r         <= neg_nxt;
      phase_r       <= phase_nxt;
      first_char_r  <= first_char_nxt;
      text_r        <= text_nxt;
      text_count_r  <= text_count_nxt;
      overflow_r    <= overflow_nxt;
      char_count_r  <= char_count_nxt;
      for (int k = 0; k < 8; k++) begin
        rec_r[k] <= rec_nxt[k];
      end
    end
  end

  // output register: load on newline, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_end) begin
      for (int k = 0; k < 8; k++) begin
        out_rec_r[k] <= rec_view[k];
      end
      out_text_r <= text_r;
      out_len_r  <= text_count_r;
      out_ovf_r  <= overflow_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_battery_level  = out_rec_r[0];
  assign out_level_a        = out_rec_r[1][6:0];
  assign out_level_b        = out_rec_r[2][6:0];
  assign out_duty_value     = out_rec_r[3][6:0];
  assign out_feel_value     = out_rec_r[4][6:0];
  assign out_mode_number    = out_rec_r[5];
  assign out_power_code     = out_rec_r[6];
  assign out_linked_value   = out_rec_r[7];
  assign out_version_text   = out_text_r;
  assign out_version_length = out_len_r;
  assign out_overflow_flag  = out_ovf_r;

  // checks
  `ASSERT_ALWAYS(a_text_count_max, text_count_r <= VERSION_CHARS, "text count too large")
  `ASSERT_IMPLIES(a_text_nonzero, text_count_r != 4'd0, text_r[7:0] != 8'd0, "kept text starts with zero")
  `ASSERT_NEXT(a_end_emits, in_fire && is_end, out_valid_r && (field_index_r == 4'd0), "newline gave no record")
  `ASSERT_IMPLIES(a_no_overwrite, out_valid_r && !out_ready, !in_ready, "byte taken while record waits")

endmodule
`default_nettype wire

// File: tb/status_line_field_parser_test.sv
// Self-checking testbench for the status line field parser
`timescale 1ns / 100ps

module status_line_field_parser_test
  import slfp_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_GOAL   = 1450;
  localparam logic [7:0] BLANKS [5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CRET};

  // One status record as it leaves the block
  typedef struct packed {
    logic [7:0]  battery;
    logic [6:0]  level_a;
    logic [6:0]  level_b;
    logic [6:0]  duty;
    logic [6:0]  feel;
    logic [7:0]  mode;
    logic [7:0]  power;
    logic [7:0]  linked;
    logic [63:0] version;
    logic [3:0]  version_len;
    logic        overflow;
  } status_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_battery_level;
  logic [6:0]  out_level_a;
  logic [6:0]  out_level_b;
  logic [6:0]  out_duty_value;
  logic [6:0]  out_feel_value;
  logic [7:0]  out_mode_number;
  logic [7:0]  out_power_code;
  logic [7:0]  out_linked_value;
  logic [63:0] out_version_text;
  logic [3:0]  out_version_length;
  logic        out_overflow_flag;

  status_line_field_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_battery_level  (out_battery_level),
    .out_level_a        (out_level_a),
    .out_level_b        (out_level_b),
    .out_duty_value     (out_duty_value),
    .out_feel_value     (out_feel_value),
    .out_mode_number    (out_mode_number),
    .out_power_code     (out_power_code),
    .out_linked_value   (out_linked_value),
    .out_version_text   (out_version_text),
    .out_version_length (out_version_length),
    .out_overflow_flag  (out_overflow_flag)
  );

  // Stimulus and scoreboard storage
  logic [7:0]  pending_bytes [$];
  status_rec_t records_due [$];
  int          n_items = 0;
  int          n_taken = 0;
  int          n_errors = 0;
  int          cycle_count = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  // Parser state mirror
  logic [3:0]  fld_idx;
  logic [7:0]  num_acc;
  logic        num_neg;
  phase_t      num_phase;
  logic [7:0]  first_ch;
  logic [63:0] text_buf;
  logic [3:0]  text_cnt;
  logic        ovf_seen;
  logic [7:0]  rec_bytes [8];
  logic [3:0]  char_cnt;

  always #5 clk = ~clk;

  task automatic clear_field();
    num_acc   = 8'h00;
    num_neg   = 1'b0;
    num_phase = PH_LEAD;
    first_ch  = 8'h00;
    char_cnt  = 4'd0;
  endtask

  task automatic clear_line();
    fld_idx  = 4'd0;
    text_buf = 64'd0;
    text_cnt = 4'd0;
    ovf_seen = 1'b0;
    foreach (rec_bytes[i]) rec_bytes[i] = 8'h00;
    clear_field();
  endtask

  // Advance the parse state by one word; queue a record on newline
  task automatic parse_byte(input logic [7:0] b);
    logic [3:0]  pos;
    logic        is_digit;
    logic        blank;
    logic [7:0]  digit_val;
    logic [7:0]  val;
    status_rec_t line_rec;
    is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    blank     = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) ||
                (b == CH_FFEED) || (b == CH_CRET);
    digit_val = b - CH_ZERO;
    pos       = char_cnt;
    if (b != SEP_BYTE && b != END_BYTE) begin
      // extra fields are ignored outright
      if (fld_idx < FIELD_COUNT && fld_idx <= TEXT_FIELD) begin
        if (char_cnt != COUNT_MAX) char_cnt = char_cnt + 4'd1;
        if (fld_idx == TEXT_FIELD) begin
          if (pos >= VERSION_CHARS) begin
            ovf_seen = 1'b1;
          end else if (num_phase == PH_STOP) begin
            // text ended by a zero byte: drop
          end else if (b == 8'h00) begin
            num_phase = PH_STOP;
          end else begin
            text_buf = text_buf | ({56'd0, b} << (8 * pos));
            text_cnt = pos + 4'd1;
          end
        end else if (pos >= FIELD_KEEP) begin
          ovf_seen = 1'b1;
        end else begin
          if (pos == 4'd0) first_ch = b;
          if (fld_idx != POWER_FIELD) begin
            case (num_phase)
              PH_LEAD: begin
                if (blank) begin
                  // skip leading white space
                end else if (b == CH_PLUS) begin
                  num_phase = PH_SIGN;
                end else if (b == CH_MINUS) begin
                  num_neg   = 1'b1;
                  num_phase = PH_SIGN;
                end else if (is_digit) begin
                  num_acc   = digit_val;
                  num_phase = PH_DIGITS;
                end else begin
                  num_phase = PH_STOP;
                end
              end
              PH_SIGN: begin
                if (is_digit) begin
                  num_acc   = digit_val;
                  num_phase = PH_DIGITS;
                end else begin
                  num_phase = PH_STOP;
                end
              end
              PH_DIGITS: begin
                if (is_digit) num_acc = num_acc * 8'd10 + digit_val;
                else num_phase = PH_STOP;
              end
              default: ;
            endcase
          end
        end
      end
    end else begin
      // close the open field
      if (fld_idx < FIELD_COUNT && fld_idx <= LAST_NUM_FIELD) begin
        if (fld_idx == POWER_FIELD) begin
          val = first_ch;
        end else begin
          if (num_phase == PH_SIGN) val = 8'h00;
          else if (num_neg) val = 8'h00 - num_acc;
          else val = num_acc;
          if (fld_idx >= 4'd1 && fld_idx <= 4'd4) val = val >> 1;
        end
        rec_bytes[fld_idx[2:0]] = val;
      end
      if (fld_idx != COUNT_MAX) fld_idx = fld_idx + 4'd1;
      clear_field();
      if (b == END_BYTE) begin
        line_rec.battery     = rec_bytes[0];
        line_rec.level_a     = rec_bytes[1][6:0];
        line_rec.level_b     = rec_bytes[2][6:0];
        line_rec.duty        = rec_bytes[3][6:0];
        line_rec.feel        = rec_bytes[4][6:0];
        line_rec.mode        = rec_bytes[5];
        line_rec.power       = rec_bytes[6];
        line_rec.linked      = rec_bytes[7];
        line_rec.version     = text_buf;
        line_rec.version_len = text_cnt;
        line_rec.overflow    = ovf_seen;
        records_due.push_back(line_rec);
        clear_line();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == SEP_BYTE || c == END_BYTE);
    return c;
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  // Numeric field: optional blanks, optional sign, digits, optional junk
  task automatic add_number();
    int n_digit;
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(BLANKS[$urandom_range(4)]);
    case ($urandom_range(5))
      0: pending_bytes.push_back(CH_MINUS);
      1: pending_bytes.push_back(CH_PLUS);
      default: ;
    endcase
    n_digit = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    repeat (n_digit) pending_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(1, 3)) pending_bytes.push_back(any_char());
  endtask

  // Text field: random characters, zero bytes now and then in the version
  task automatic add_text(input logic is_version);
    int n_char;
    n_char = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
    repeat (n_char) begin
      if (is_version && $urandom_range(15) == 0) pending_bytes.push_back(8'h00);
      else pending_bytes.push_back(any_char());
    end
  endtask

  task automatic add_line();
    int n_fields;
    n_fields = ($urandom_range(9) < 7) ? 9 : $urandom_range(17);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) pending_bytes.push_back(SEP_BYTE);
      if (f == POWER_FIELD || f >= TEXT_FIELD) add_text(f == TEXT_FIELD);
      else add_number();
    end
    pending_bytes.push_back(END_BYTE);
  endtask

  // Drive input words; predict on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        n_taken <= n_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Take records and compare with the oldest prediction
  always @(posedge clk) begin
    status_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (records_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("record with none expected");
        end else begin
          want = records_due.pop_front();
          check_field("battery_level", 64'(want.battery), 64'(out_battery_level));
          check_field("level_a", 64'(want.level_a), 64'(out_level_a));
          check_field("level_b", 64'(want.level_b), 64'(out_level_b));
          check_field("duty_value", 64'(want.duty), 64'(out_duty_value));
          check_field("feel_value", 64'(want.feel), 64'(out_feel_value));
          check_field("mode_number", 64'(want.mode), 64'(out_mode_number));
          check_field("power_code", 64'(want.power), 64'(out_power_code));
          check_field("linked_value", 64'(want.linked), 64'(out_linked_value));
          check_field("version_text", want.version, out_version_text);
          check_field("version_length", 64'(want.version_len), 64'(out_version_length));
          check_field("overflow_flag", 64'(want.overflow), 64'(out_overflow_flag));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n_lines;
    n_lines = 0;
    clear_line();

    // empty line: every field stays zero
    pending_bytes.push_back(END_BYTE);
    // sign only, long number, empty field, blank then digit, 255, extreme bytes
    add_str("-1:+:9999999999:: 7:255:");
    pending_bytes.push_back(8'hff);
    add_str(":-0:AB");
    pending_bytes.push_back(8'h00);
    add_str("C\n");
    // empty fields, sign then junk, blank after sign, nine characters in a numeric field, short version text
    add_str("::::+x:- 5::ABCDEFGHI:z");
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(END_BYTE);

    // random lines with some raw noise in between
    while (pending_bytes.size() < ITEM_GOAL || n_lines < 20) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 20)) pending_bytes.push_back(8'($urandom_range(255)));
      end else begin
        add_line();
        n_lines++;
      end
    end
    n_items = pending_bytes.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // step through the pacing phases
    while (n_taken < n_items / 6) @(posedge clk);
    src_idle_pct <= 57;
    while (n_taken < 2 * n_items / 6) @(posedge clk);
    src_idle_pct  <= 0;
    snk_stall_pct <= 57;
    while (n_taken < 3 * n_items / 6) @(posedge clk);
    src_idle_pct  <= 27;
    snk_stall_pct <= 27;
    while (n_taken < 4 * n_items / 6) @(posedge clk);
    src_idle_pct  <= 0;
    snk_stall_pct <= 0;
    hold_req      <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    while (n_taken < 5 * n_items / 6) @(posedge clk);
    src_idle_pct  <= 27;
    snk_stall_pct <= 27;

    // drain
    while (n_taken < n_items) @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
